[sv/modexp_pkg.sv]
package modexp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  // Fixed widths of the payload and configuration data
  localparam int unsigned DATA_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture message, start base reduction
    logic start_sqr;  // acc <= acc * acc mod n
    logic start_mul;  // acc <= acc * base mod n
    logic emit;       // copy acc into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic small_mod;  // modulus below two
    logic busy;       // modular multiplier is stepping
    logic mul_done;   // multiplier finished last cycle
  } sts_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BASE = 5'b00010,
    ST_SQR  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage

[sv/modexp_datapath.sv]
module modexp_datapath #(
  parameter int WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  modexp_pkg::cmd_t             cmd,
  input  logic [modexp_pkg::DATA_W-1:0] message_value,
  input  logic [WIDTH-1:0]             modulus,
  output modexp_pkg::sts_t             sts,
  output logic [modexp_pkg::DATA_W-1:0] cipher_value
);
  import modexp_pkg::*;

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] prod;
  logic [WIDTH-1:0] ma;
  logic [WIDTH-1:0] mb;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic             dest_acc;
  logic [DATA_W-1:0] cipher;

  logic [WIDTH:0]   dbl_sum;
  logic [WIDTH:0]   add_sum;
  logic [WIDTH-1:0] dbl_val;
  logic [WIDTH-1:0] step_val;
  logic             small_mod;

  assign small_mod = (modulus < WIDTH'(2));

  // One shift-and-add step: prod <= 2*prod (+ ma) mod n
  always_comb begin
    dbl_sum = {1'b0, prod} + {1'b0, prod};
    if (dbl_sum >= {1'b0, modulus}) begin
      dbl_val = WIDTH'(dbl_sum - {1'b0, modulus});
    end else begin
      dbl_val = WIDTH'(dbl_sum);
    end
    add_sum = {1'b0, dbl_val} + {1'b0, ma};
    if (!mb[WIDTH-1]) begin
      step_val = dbl_val;
    end else if (add_sum >= {1'b0, modulus}) begin
      step_val = WIDTH'(add_sum - {1'b0, modulus});
    end else begin
      step_val = WIDTH'(add_sum);
    end
  end

  // Control bits of the multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        busy <= !small_mod;
      end else if (cmd.start_sqr || cmd.start_mul) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operands, running product and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc      <= small_mod ? '0 : WIDTH'(1);
      prod     <= '0;
      ma       <= WIDTH'(1);
      mb       <= WIDTH'(message_value);
      cnt      <= CNT_W'(WIDTH - 1);
      dest_acc <= 1'b0;
    end else if (cmd.start_sqr) begin
      prod     <= '0;
      ma       <= acc;
      mb       <= acc;
      cnt      <= CNT_W'(WIDTH - 1);
      dest_acc <= 1'b1;
    end else if (cmd.start_mul) begin
      prod     <= '0;
      ma       <= base;
      mb       <= acc;
      cnt      <= CNT_W'(WIDTH - 1);
      dest_acc <= 1'b1;
    end else if (busy) begin
      prod <= step_val;
      mb   <= mb << 1;
      cnt  <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        if (dest_acc) begin
          acc <= step_val;
        end else begin
          base <= step_val;
        end
      end
    end
    if (cmd.emit) begin
      cipher <= DATA_W'(acc);
    end
  end

  assign sts.small_mod = small_mod;
  assign sts.busy      = busy;
  assign sts.mul_done  = done;
  assign cipher_value  = cipher;

endmodule

[sv/modexp_ctrl.sv]
module modexp_ctrl #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [WIDTH-1:0] exponent,
  input  modexp_pkg::sts_t sts,
  output modexp_pkg::cmd_t cmd
);
  import modexp_pkg::*;

  localparam int K_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  state_t         state;
  state_t         state_next;
  logic [K_W-1:0] k;
  logic [K_W-1:0] k_next;
  logic           out_valid_next;
  logic           accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Sequence: reduce base unless modulus < 2, then square per exponent bit, multiply if set
  always_comb begin
    cmd            = '0;
    state_next     = state;
    k_next         = k;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = sts.small_mod ? ST_OUT : ST_BASE;
        end
      end
      ST_BASE: begin
        if (sts.mul_done) begin
          k_next        = K_W'(WIDTH - 1);
          cmd.start_sqr = 1'b1;
          state_next    = ST_SQR;
        end
      end
      ST_SQR: begin
        if (sts.mul_done) begin
          if (exponent[k]) begin
            cmd.start_mul = 1'b1;
            state_next    = ST_MUL;
          end else if (k == '0) begin
            state_next = ST_OUT;
          end else begin
            k_next        = k - K_W'(1);
            cmd.start_sqr = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (sts.mul_done) begin
          if (k == '0) begin
            state_next = ST_OUT;
          end else begin
            k_next        = k - K_W'(1);
            cmd.start_sqr = 1'b1;
            state_next    = ST_SQR;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state, bit index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_start_idle_mult: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_sqr || cmd.start_mul || cmd.load) |-> !sts.busy)
    else $error("multiplier started while busy");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_small_mod_skip: assert property (@(posedge clk) disable iff (rst)
    (accept && sts.small_mod) |=> (state == ST_OUT))
    else $error("small modulus did not go straight to output");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == ST_BASE || state == ST_SQR || state == ST_MUL))
    else $error("multiplier finished outside a wait state");
`endif

endmodule

[sv/modular_exponentiation_top.sv]
// Computes cipher_value = message_value ^ exponent mod modulus (left-to-right
// binary method). The message is first reduced mod n, then each exponent bit
// from the top down costs one modular squaring plus one modular multiply when
// the bit is set. All products run on one shared bit-serial shift-and-add
// multiplier. A modulus below two returns 0 and skips the multiplier. One
// item is worked at a time; a finished result sits in an output register,
// and the next transaction is accepted while it waits. Write modulus and
// exponent only while the block is idle; both keep their low WIDTH bits.
module modular_exponentiation_top #(
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [modexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [modexp_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [modexp_pkg::DATA_W-1:0]    message_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [modexp_pkg::DATA_W-1:0]    cipher_value
);
  import modexp_pkg::*;

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] exponent;
  cmd_t             cmd;
  sts_t             sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WIDTH'(2);
      exponent <= WIDTH'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= WIDTH'(cfg_wdata);
        REG_EXPONENT: exponent <= WIDTH'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  modexp_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .exponent (exponent),
    .sts      (sts),
    .cmd      (cmd)
  );

  modexp_datapath #(
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_value(message_value),
    .modulus      (modulus),
    .sts          (sts),
    .cipher_value (cipher_value)
  );

endmodule
